@@ rtl/ppc_pkg.sv @@
// Shared types, constants and the arctangent table for planar pose composition.
package ppc_pkg;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [23:0] start_heading;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [23:0] offset_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [23:0] result_heading;
    logic               saturated;
  } out_item_t;

  localparam int unsigned AtanCount = 32;

  localparam logic signed [25:0] PiQ20     = 26'sd3294199;
  localparam logic signed [25:0] HalfPiQ20 = 26'sd1647099;
  localparam logic signed [25:0] TwoPiQ20  = 26'sd6588397;

  // CORDIC datapath is Q2.30 plus headroom.
  localparam int unsigned CordW = 34;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;

  // z lane width: angle up to about pi/2 in 2^-30 units, plus margin.
  localparam int unsigned ZW = 33;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 33'sd843314857;
      5'd1:  v = 33'sd497837829;
      5'd2:  v = 33'sd263043837;
      5'd3:  v = 33'sd133525159;
      5'd4:  v = 33'sd67021687;
      5'd5:  v = 33'sd33543516;
      5'd6:  v = 33'sd16775851;
      5'd7:  v = 33'sd8388437;
      5'd8:  v = 33'sd4194283;
      5'd9:  v = 33'sd2097149;
      5'd10: v = 33'sd1048576;
      5'd11: v = 33'sd524288;
      5'd12: v = 33'sd262144;
      5'd13: v = 33'sd131072;
      5'd14: v = 33'sd65536;
      5'd15: v = 33'sd32768;
      5'd16: v = 33'sd16384;
      5'd17: v = 33'sd8192;
      5'd18: v = 33'sd4096;
      5'd19: v = 33'sd2048;
      5'd20: v = 33'sd1024;
      5'd21: v = 33'sd512;
      5'd22: v = 33'sd256;
      5'd23: v = 33'sd128;
      5'd24: v = 33'sd64;
      5'd25: v = 33'sd32;
      5'd26: v = 33'sd16;
      5'd27: v = 33'sd8;
      5'd28: v = 33'sd4;
      5'd29: v = 33'sd2;
      5'd30: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ppc_cordic_stage.sv @@
// One registered CORDIC rotation stage with its side payload.
module ppc_cordic_stage #(
  parameter int unsigned STAGE  = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [ppc_pkg::CordW-1:0]  in_x,
  input  logic signed [ppc_pkg::CordW-1:0]  in_y,
  input  logic signed [ppc_pkg::ZW-1:0]     in_z,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic signed [ppc_pkg::CordW-1:0]  out_x,
  output logic signed [ppc_pkg::CordW-1:0]  out_y,
  output logic signed [ppc_pkg::ZW-1:0]     out_z,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam logic [4:0] Idx = 5'(STAGE);

  logic signed [ppc_pkg::CordW-1:0] xs, ys, x_next, y_next;
  logic signed [ppc_pkg::ZW-1:0]    a, z_next;

  always_comb begin
    xs = in_x >>> STAGE;
    ys = in_y >>> STAGE;
    a  = ppc_pkg::atan_q30(Idx);
    if (!in_z[ppc_pkg::ZW-1]) begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - a;
    end else begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end

endmodule

@@ rtl/ppc_rotate.sv @@
// Rotate-and-add back end: products, rounding, position and heading saturation.
module ppc_rotate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [ppc_pkg::CordW-1:0]  cos_v,
  input  logic signed [ppc_pkg::CordW-1:0]  sin_v,
  input  logic                              neg,
  input  ppc_pkg::in_item_t                 item,
  input  logic signed [24:0]                heading_sum,
  input  logic                              norm,
  output logic                              out_valid,
  output ppc_pkg::out_item_t                out_item
);

  // Stage A: sign fix of sin/cos and heading finish
  logic                             va;
  logic signed [ppc_pkg::CordW-1:0] ca, sa;
  logic signed [31:0]               oxa, oya, sxa, sya;
  logic signed [23:0]               ha;
  logic                             hsa;

  logic signed [25:0] hw;
  logic signed [23:0] h_fin;
  logic               h_sat;

  always_comb begin
    hw    = 26'(heading_sum);
    h_sat = 1'b0;
    if (norm) begin
      // sum lies in [-2^24, 2^24); at most three steps of 2*pi
      if (hw >= ppc_pkg::PiQ20)  hw = hw - ppc_pkg::TwoPiQ20;
      if (hw >= ppc_pkg::PiQ20)  hw = hw - ppc_pkg::TwoPiQ20;
      if (hw >= ppc_pkg::PiQ20)  hw = hw - ppc_pkg::TwoPiQ20;
      if (hw < -ppc_pkg::PiQ20)  hw = hw + ppc_pkg::TwoPiQ20;
      if (hw < -ppc_pkg::PiQ20)  hw = hw + ppc_pkg::TwoPiQ20;
      if (hw < -ppc_pkg::PiQ20)  hw = hw + ppc_pkg::TwoPiQ20;
      h_fin = hw[23:0];
    end else if (heading_sum > 25'sd8388607) begin
      h_fin = 24'sd8388607;
      h_sat = 1'b1;
    end else if (heading_sum < -25'sd8388608) begin
      h_fin = -24'sd8388608;
      h_sat = 1'b1;
    end else begin
      h_fin = heading_sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca  <= neg ? -cos_v : cos_v;
      sa  <= neg ? -sin_v : sin_v;
      oxa <= item.offset_x;
      oya <= item.offset_y;
      sxa <= item.start_x;
      sya <= item.start_y;
      ha  <= h_fin;
      hsa <= h_sat;
    end
  end

  // Stage B: four products (32 x 34 each)
  localparam int unsigned PW = 66;
  logic                 vb;
  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [31:0]   sxb, syb;
  logic signed [23:0]   hb;
  logic                 hsb;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= PW'(oxa) * PW'(ca);
      p_ys <= PW'(oya) * PW'(sa);
      p_xs <= PW'(oxa) * PW'(sa);
      p_yc <= PW'(oya) * PW'(ca);
      sxb  <= sxa;
      syb  <= sya;
      hb   <= ha;
      hsb  <= hsa;
    end
  end

  // Stage C: combine, round to Q16
  logic                 vc;
  logic signed [35:0]   dxc, dyc;
  logic signed [31:0]   sxc, syc;
  logic signed [23:0]   hc;
  logic                 hsc;
  logic signed [PW-1:0] sum_x, sum_y;

  localparam logic signed [PW-1:0] RoundK = PW'(64'sd1 << 29);

  always_comb begin
    sum_x = p_xc - p_ys + RoundK;
    sum_y = p_xs + p_yc + RoundK;
  end

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxc <= sum_x[PW-1:30];
      dyc <= sum_y[PW-1:30];
      sxc <= sxb;
      syc <= syb;
      hc  <= hb;
      hsc <= hsb;
    end
  end

  // Stage D: add start position and saturate
  logic signed [37:0] rx, ry;
  logic signed [31:0] rxs, rys;
  logic               sx_sat, sy_sat;

  localparam logic signed [37:0] MaxP = 38'sd2147483647;
  localparam logic signed [37:0] MinP = -38'sd2147483648;

  always_comb begin
    rx = 38'(sxc) + 38'(dxc);
    ry = 38'(syc) + 38'(dyc);
    sx_sat = 1'b1;
    sy_sat = 1'b1;
    if (rx > MaxP)      rxs = 32'sh7fffffff;
    else if (rx < MinP) rxs = 32'sh80000000;
    else begin rxs = rx[31:0]; sx_sat = 1'b0; end
    if (ry > MaxP)      rys = 32'sh7fffffff;
    else if (ry < MinP) rys = 32'sh80000000;
    else begin rys = ry[31:0]; sy_sat = 1'b0; end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.result_x       <= rxs;
      out_item.result_y       <= rys;
      out_item.result_heading <= hc;
      out_item.saturated      <= sx_sat | sy_sat | hsc;
    end
  end

endmodule

@@ rtl/planar_pose_compose.sv @@
// Top level of the planar pose composition pipeline.
// Composes a start pose with a local offset, one transaction per cycle: the
// start heading is folded into [-pi/2, pi/2], sine and cosine come from an
// unrolled CORDIC of TRIG_STAGES registered stages (at most AtanCount), then
// four registered 32x34 multiplies, a rounding stage and a saturating add.
// Throughput is one transaction per cycle. The whole pipe advances together:
// it holds when the output register is full and not being taken, so ready
// is high whenever the output can move or is empty. normalise_heading is
// sampled as a transaction enters and reset sets it to 1.
module planar_pose_compose #(
  parameter int unsigned TRIG_STAGES = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ppc_pkg::out_item_t  out_item
);

  localparam int unsigned NStages = (TRIG_STAGES > ppc_pkg::AtanCount) ?
                                    ppc_pkg::AtanCount : TRIG_STAGES;
  localparam int unsigned CW = ppc_pkg::CordW;
  localparam int unsigned ZW = ppc_pkg::ZW;
  // Side payload: item, 25-bit heading sum, normalise flag, negate flag.
  localparam int unsigned SideW = $bits(ppc_pkg::in_item_t) + 25 + 2;

  logic normalise_heading;
  logic en;

  // Advance whenever the output slot is empty or being drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      normalise_heading <= 1'b1;
    end else if (cfg_we) begin
      normalise_heading <= cfg_data;
    end
  end

  // Entry stage: wrap start heading, fold into the CORDIC range
  logic signed [25:0] r;
  logic               fold_neg;
  logic signed [ZW-1:0] z0;
  logic signed [24:0] hsum;

  always_comb begin
    r = 26'(in_item.start_heading);
    if (r >= ppc_pkg::PiQ20)  r = r - ppc_pkg::TwoPiQ20;
    if (r < -ppc_pkg::PiQ20)  r = r + ppc_pkg::TwoPiQ20;
    fold_neg = 1'b0;
    if (r > ppc_pkg::HalfPiQ20) begin
      r = r - ppc_pkg::PiQ20;
      fold_neg = 1'b1;
    end else if (r < -ppc_pkg::HalfPiQ20) begin
      r = r + ppc_pkg::PiQ20;
      fold_neg = 1'b1;
    end
    z0   = ZW'(r) <<< 10;
    hsum = 25'(in_item.start_heading) + 25'(in_item.offset_heading);
  end

  logic                 v_q  [NStages+1];
  logic signed [CW-1:0] x_q  [NStages+1];
  logic signed [CW-1:0] y_q  [NStages+1];
  logic signed [ZW-1:0] z_q  [NStages+1];
  logic [SideW-1:0]     s_q  [NStages+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0] <= ppc_pkg::CordicGain;
      y_q[0] <= '0;
      z_q[0] <= z0;
      s_q[0] <= {in_item, hsum, normalise_heading, fold_neg};
    end
  end

  for (genvar i = 0; i < NStages; i++) begin : g_cordic
    ppc_cordic_stage #(
      .STAGE  (i),
      .SIDE_W (SideW)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_q[i]),
      .in_x      (x_q[i]),
      .in_y      (y_q[i]),
      .in_z      (z_q[i]),
      .in_side   (s_q[i]),
      .out_valid (v_q[i+1]),
      .out_x     (x_q[i+1]),
      .out_y     (y_q[i+1]),
      .out_z     (z_q[i+1]),
      .out_side  (s_q[i+1])
    );
  end

  // Unpack the side payload at the CORDIC exit; z is spent.
  ppc_pkg::in_item_t  c_item;
  logic signed [24:0] c_hsum;
  logic               c_norm, c_neg;
  logic signed [ZW-1:0] z_spent;

  assign {c_item, c_hsum, c_norm, c_neg} = s_q[NStages];
  assign z_spent = z_q[NStages];

  ppc_rotate u_rotate (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (v_q[NStages] & (z_spent[0] | 1'b1)),
    .cos_v       (x_q[NStages]),
    .sin_v       (y_q[NStages]),
    .neg         (c_neg),
    .item        (c_item),
    .heading_sum (c_hsum),
    .norm        (c_norm),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule
